>>> hw/rtl/tcsr_pkg.sv
// Shared constants and command codes for the textured column span renderer.
package tcsr_pkg;

  localparam int IMG_ROWS         = 512;
  localparam int ROW_W            = $clog2(IMG_ROWS + 1);
  localparam int WALL_TEX_SIZE    = 64;
  localparam int WALL_TEX_BITS    = $clog2(WALL_TEX_SIZE);
  localparam int WALL_TEXTURES    = 5;
  localparam int WALL_SIDE_BITS   = 3;
  localparam int WALL_DEPTH       = WALL_TEXTURES * WALL_TEX_SIZE * WALL_TEX_SIZE;
  localparam int WALL_AW          = WALL_SIDE_BITS + 2 * WALL_TEX_BITS;
  localparam int OVL_TEX_SIZE     = 128;
  localparam int OVL_TEX_BITS     = $clog2(OVL_TEX_SIZE);
  localparam int OVL_FRAMES       = 4;
  localparam int OVL_FRAME_BITS   = 2;
  localparam int OVL_DEPTH        = OVL_FRAMES * OVL_TEX_SIZE * OVL_TEX_SIZE;
  localparam int OVL_AW           = OVL_FRAME_BITS + 2 * OVL_TEX_BITS;
  localparam int TEXEL_W          = 32;
  localparam int COLOR_W          = 24;
  localparam int FRAC_BITS        = 16;

  localparam logic [COLOR_W-1:0] SHADE_MASK = 24'h7F7F7F;

  // Command codes carried on the input tuser
  localparam logic [1:0] CMD_LOAD_WALL    = 2'd0;
  localparam logic [1:0] CMD_LOAD_OVERLAY = 2'd1;
  localparam logic [1:0] CMD_START        = 2'd2;
  localparam logic [1:0] CMD_PIXEL        = 2'd3;

  // Configuration register indexes
  localparam logic CFG_FLOOR_COLOR   = 1'b0;
  localparam logic CFG_CEILING_COLOR = 1'b1;

  // Pixel item between the fetch stage and the output register
  typedef struct packed {
    logic                is_wall;
    logic [COLOR_W-1:0]  flat_color;
    logic                shade;
    logic                side_ok;
    logic                ovl_on;
    logic [8:0]          row;
    logic [9:0]          column;
    logic                last;
  } tcsr_pix_t;

endpackage

>>> hw/rtl/textured_column_span_renderer_core.sv
// Top level of the textured column span renderer: command decode, texel fetch, pixel output.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready with the command on s_tuser.
//   Load commands write one texel into the wall store (5 textures of 64x64)
//   or the overlay store (4 frames of 128x128). A start command latches the
//   column setup and resets the row count. Each pixel command yields one
//   output item on m_tvalid/m_tready until row 511 is out; later pixel
//   commands yield nothing until the next start.
//   Floor and ceiling colors are written on cfg_we/cfg_index/cfg_data while
//   the block is idle.
// Timing:
//   One item is accepted per cycle while s_tready is high. For a pixel the
//   texel stores are read with registered data at the accepting edge, and
//   the color is merged into the output register once that register is
//   free. A load is seen by any pixel accepted after it.
// Reset:
//   rst clears row count, texture position, column setup, colors and all
//   valid flags. The texel stores are not cleared and need no clearing pass.
// Stall:
//   While m_tvalid is high and m_tready is low the output register holds;
//   the fetch stage still fills once, then s_tready drops until the output drains.
module textured_column_span_renderer_core
  import tcsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata from bit 0: texel_addr(14) texel_value(32) side(3) tex_column(6)
  // tex_start(31) tex_step(31) wall_top(9) wall_bottom(9) overlay_on(1)
  // overlay_frame(2) screen_column(10), zero pad(4)
  input  logic [151:0] s_tdata,
  // s_tuser: command(2)
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0: pixel_row(9) pixel_column(10) pixel_color(32), zero pad(5)
  output logic [55:0]  m_tdata,
  // m_tlast: last_pixel
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_data
);

  // Input field slices
  logic [1:0]   in_command;
  logic [13:0]  in_texel_addr;
  logic [31:0]  in_texel_value;
  logic [2:0]   in_side;
  logic [5:0]   in_tex_column;
  logic [30:0]  in_tex_start;
  logic [30:0]  in_tex_step;
  logic [8:0]   in_wall_top;
  logic [8:0]   in_wall_bottom;
  logic         in_overlay_on;
  logic [1:0]   in_overlay_frame;
  logic [9:0]   in_screen_column;

  assign in_command       = s_tuser;
  assign in_texel_addr    = s_tdata[13:0];
  assign in_texel_value   = s_tdata[45:14];
  assign in_side          = s_tdata[48:46];
  assign in_tex_column    = s_tdata[54:49];
  assign in_tex_start     = s_tdata[85:55];
  assign in_tex_step      = s_tdata[116:86];
  assign in_wall_top      = s_tdata[125:117];
  assign in_wall_bottom   = s_tdata[134:126];
  assign in_overlay_on    = s_tdata[135];
  assign in_overlay_frame = s_tdata[137:136];
  assign in_screen_column = s_tdata[147:138];

  // Configuration registers
  logic [COLOR_W-1:0] floor_color;
  logic [COLOR_W-1:0] ceiling_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_color   <= '0;
      ceiling_color <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLOOR_COLOR:   floor_color   <= cfg_data;
        CFG_CEILING_COLOR: ceiling_color <= cfg_data;
        default:           floor_color   <= floor_color;
      endcase
    end
  end

  // Column state
  logic [ROW_W-1:0]          row_counter;
  logic [31:0]               tex_position;
  logic [WALL_SIDE_BITS-1:0] setup_side;
  logic [5:0]                setup_tex_column;
  logic [30:0]               setup_tex_step;
  logic [8:0]                setup_wall_top;
  logic [8:0]                setup_wall_bottom;
  logic                      setup_overlay_on;
  logic [OVL_FRAME_BITS-1:0] setup_overlay_frame;
  logic [9:0]                setup_screen_column;

  // Pipeline control
  logic      s1_valid;
  tcsr_pix_t s1_pix;
  logic      s1_en;
  logic      s2_en;
  logic      accept;

  assign s2_en    = !m_tvalid || m_tready;
  assign s1_en    = !s1_valid || s2_en;
  assign s_tready = s1_en;
  assign accept   = s_tvalid && s_tready;

  // Pixel decode against the current column state
  logic      row_live;
  logic      pix_fire;
  logic      in_floor;
  logic      in_wall;
  logic      side_ok;
  tcsr_pix_t pix_next;

  assign row_live = row_counter < ROW_W'(IMG_ROWS);
  assign pix_fire = accept && (in_command == CMD_PIXEL) && row_live;
  assign in_floor = row_counter <= {1'b0, setup_wall_top};
  assign in_wall  = !in_floor && (row_counter <= {1'b0, setup_wall_bottom});
  assign side_ok  = setup_side < WALL_SIDE_BITS'(WALL_TEXTURES);

  always_comb begin
    pix_next.is_wall    = in_wall;
    pix_next.flat_color = in_floor ? floor_color : ceiling_color;
    pix_next.shade      = setup_side != '0;
    pix_next.side_ok    = side_ok;
    pix_next.ovl_on     = setup_overlay_on;
    pix_next.row        = row_counter[8:0];
    pix_next.column     = setup_screen_column;
    pix_next.last       = row_counter == ROW_W'(IMG_ROWS - 1);
  end

  // Texel stores: write on load items, read on wall rows of pixel items
  logic                wall_we;
  logic [WALL_AW-1:0]  wall_waddr;
  logic                wall_re;
  logic [WALL_AW-1:0]  wall_raddr;
  logic [TEXEL_W-1:0]  wall_rdata;
  logic                ovl_we;
  logic [OVL_AW-1:0]   ovl_waddr;
  logic                ovl_re;
  logic [OVL_AW-1:0]   ovl_raddr;
  logic [TEXEL_W-1:0]  ovl_rdata;

  // Drop wall loads outside the textures or beyond one texture's area
  assign wall_we    = accept && (in_command == CMD_LOAD_WALL)
                      && (in_side < WALL_SIDE_BITS'(WALL_TEXTURES))
                      && (in_texel_addr[13:2*WALL_TEX_BITS] == '0);
  assign wall_waddr = {in_side, in_texel_addr[2*WALL_TEX_BITS-1:0]};
  assign wall_re    = pix_fire && in_wall && side_ok;
  assign wall_raddr = {setup_side, tex_position[FRAC_BITS +: WALL_TEX_BITS],
                       setup_tex_column[WALL_TEX_BITS-1:0]};

  assign ovl_we     = accept && (in_command == CMD_LOAD_OVERLAY);
  assign ovl_waddr  = {in_overlay_frame, in_texel_addr};
  assign ovl_re     = pix_fire && in_wall && setup_overlay_on;
  assign ovl_raddr  = {setup_overlay_frame, tex_position[FRAC_BITS +: OVL_TEX_BITS],
                       1'b0, setup_tex_column};

  tcsr_ram #(
    .DEPTH (WALL_DEPTH),
    .AW    (WALL_AW),
    .DW    (TEXEL_W)
  ) u_wall_ram (
    .clk   (clk),
    .we    (wall_we),
    .waddr (wall_waddr),
    .wdata (in_texel_value),
    .re    (wall_re),
    .raddr (wall_raddr),
    .rdata (wall_rdata)
  );

  tcsr_ram #(
    .DEPTH (OVL_DEPTH),
    .AW    (OVL_AW),
    .DW    (TEXEL_W)
  ) u_ovl_ram (
    .clk   (clk),
    .we    (ovl_we),
    .waddr (ovl_waddr),
    .wdata (in_texel_value),
    .re    (ovl_re),
    .raddr (ovl_raddr),
    .rdata (ovl_rdata)
  );

  // Column state update at the accepting edge
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter         <= '0;
      tex_position        <= '0;
      setup_side          <= '0;
      setup_tex_column    <= '0;
      setup_tex_step      <= '0;
      setup_wall_top      <= '0;
      setup_wall_bottom   <= '0;
      setup_overlay_on    <= 1'b0;
      setup_overlay_frame <= '0;
      setup_screen_column <= '0;
    end else if (accept && (in_command == CMD_START)) begin
      row_counter         <= '0;
      tex_position        <= {1'b0, in_tex_start};
      setup_side          <= in_side;
      setup_tex_column    <= in_tex_column;
      setup_tex_step      <= in_tex_step;
      setup_wall_top      <= in_wall_top;
      setup_wall_bottom   <= in_wall_bottom;
      setup_overlay_on    <= in_overlay_on;
      setup_overlay_frame <= in_overlay_frame;
      setup_screen_column <= in_screen_column;
    end else if (pix_fire) begin
      row_counter <= row_counter + 1'b1;
      // Advance the texture row only on wall rows
      if (in_wall) begin
        tex_position <= tex_position + {1'b0, setup_tex_step};
      end
    end
  end

  // Fetch stage: hold the pixel while the texel read data waits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= pix_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_pix <= pix_next;
    end
  end

  // Merge: shade the wall texel, then let a positive overlay texel win
  logic [TEXEL_W-1:0] wall_texel;
  logic [TEXEL_W-1:0] wall_shaded;
  logic               ovl_hit;
  logic [TEXEL_W-1:0] color_next;

  assign wall_texel  = s1_pix.side_ok ? wall_rdata : '0;
  assign wall_shaded = s1_pix.shade
                       ? {{(TEXEL_W - COLOR_W){1'b0}}, wall_texel[COLOR_W:1] & SHADE_MASK}
                       : wall_texel;
  assign ovl_hit     = s1_pix.ovl_on && !ovl_rdata[TEXEL_W-1] && (ovl_rdata != '0);

  always_comb begin
    if (!s1_pix.is_wall) begin
      color_next = {{(TEXEL_W - COLOR_W){1'b0}}, s1_pix.flat_color};
    end else if (ovl_hit) begin
      color_next = ovl_rdata;
    end else begin
      color_next = wall_shaded;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_en) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      m_tdata <= {5'd0, color_next, s1_pix.column, s1_pix.row};
      m_tlast <= s1_pix.last;
    end
  end

endmodule

>>> hw/rtl/tcsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcsr_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the textured column span renderer core.
module tb_top;
  import tcsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WALL_AREA   = WALL_TEX_SIZE * WALL_TEX_SIZE;
  localparam int OVL_AREA    = OVL_TEX_SIZE * OVL_TEX_SIZE;
  localparam int STALL_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int DRAIN_WAIT  = 6;     // fetch and output registers, plus margin
  localparam int MAX_REPORTS = 30;

  // One input item, field by field
  typedef struct {
    logic [1:0]  cmd;
    logic [13:0] addr;
    logic [31:0] value;
    logic [2:0]  side;
    logic [5:0]  tcol;
    logic [30:0] start;
    logic [30:0] step;
    logic [8:0]  top;
    logic [8:0]  bottom;
    logic        ovl_on;
    logic [1:0]  frame;
    logic [9:0]  scol;
  } span_item_t;

  // Column setup latched by a start command
  typedef struct {
    logic [2:0]  side;
    logic [5:0]  tcol;
    logic [30:0] step;
    logic [8:0]  top;
    logic [8:0]  bottom;
    logic        ovl_on;
    logic [1:0]  frame;
    logic [9:0]  scol;
  } column_t;

  // One output pixel
  typedef struct {
    logic [8:0]  row;
    logic [9:0]  column;
    logic [31:0] color;
    logic        last;
  } pixel_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // s_tdata from bit 0: texel_addr(14) texel_value(32) side(3) tex_column(6)
  // tex_start(31) tex_step(31) wall_top(9) wall_bottom(9) overlay_on(1)
  // overlay_frame(2) screen_column(10), zero pad(4)
  logic [151:0] s_tdata = '0;
  // s_tuser: command(2)
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // m_tdata from bit 0: pixel_row(9) pixel_column(10) pixel_color(32), zero pad(5)
  logic [55:0]  m_tdata;
  // m_tlast: last_pixel
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [23:0]  cfg_data = '0;

  // Predictor state: texel stores with written flags, column setup, row count,
  // texture position and the two flat colors.
  logic [31:0]    wall_store [WALL_DEPTH];
  bit             wall_written [WALL_DEPTH];
  logic [31:0]    ovl_store [OVL_DEPTH];
  bit             ovl_written [OVL_DEPTH];
  column_t        span = '{default: '0};
  int             span_row = 0;
  logic [31:0]    span_pos = '0;
  logic [23:0]    floor_rgb = '0;
  logic [23:0]    ceil_rgb = '0;
  pixel_t         pixels_due[$];

  int send_gap_pct   = 16;
  int recv_stall_pct = 76;
  int errors         = 0;
  int items_taken    = 0;
  int texel_loads    = 0;
  int column_starts  = 0;
  int wall_rows      = 0;
  int pixels_seen    = 0;

  textured_column_span_renderer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Wall texel for the current position: row from the integer part of the
  // position, column from the latched texture column.
  function automatic int wall_slot();
    return int'(span.side) * WALL_AREA
         + int'((span_pos >> FRAC_BITS) % WALL_TEX_SIZE) * WALL_TEX_SIZE
         + int'(span.tcol) % WALL_TEX_SIZE;
  endfunction

  function automatic int ovl_slot();
    return int'(span.frame) * OVL_AREA
         + int'((span_pos >> FRAC_BITS) % OVL_TEX_SIZE) * OVL_TEX_SIZE
         + int'(span.tcol) % OVL_TEX_SIZE;
  endfunction

  function automatic bit next_is_wall();
    return span_row < IMG_ROWS && span_row > span.top && span_row <= span.bottom;
  endfunction

  // Wall color: missing texture reads as zero, shaded faces are halved per
  // channel, and a positive overlay texel wins over both.
  function automatic logic [31:0] wall_hue();
    logic [31:0] c;
    logic [31:0] o;
    c = '0;
    if (span.side < WALL_TEXTURES) c = wall_store[wall_slot()];
    if (span.side != 0) c = (c >> 1) & {8'h00, SHADE_MASK};
    if (span.ovl_on && span.frame < OVL_FRAMES) begin
      o = ovl_store[ovl_slot()];
      if ($signed(o) > 0) c = o;
    end
    return c;
  endfunction

  // Advance the predictor by one accepted item; queue the pixel it yields.
  function automatic void advance_column(span_item_t it);
    int     idx;
    pixel_t px;
    items_taken++;
    case (it.cmd)
      CMD_LOAD_WALL: begin
        // out-of-range side or address: dropped by the block
        if (it.side < WALL_TEXTURES && it.addr < WALL_AREA) begin
          idx = int'(it.side) * WALL_AREA + int'(it.addr);
          wall_store[idx] = it.value;
          wall_written[idx] = 1'b1;
          texel_loads++;
        end
      end
      CMD_LOAD_OVERLAY: begin
        if (it.frame < OVL_FRAMES && it.addr < OVL_AREA) begin
          idx = int'(it.frame) * OVL_AREA + int'(it.addr);
          ovl_store[idx] = it.value;
          ovl_written[idx] = 1'b1;
          texel_loads++;
        end
      end
      CMD_START: begin
        span.side   = it.side;
        span.tcol   = it.tcol;
        span.step   = it.step;
        span.top    = it.top;
        span.bottom = it.bottom;
        span.ovl_on = it.ovl_on;
        span.frame  = it.frame;
        span.scol   = it.scol;
        span_pos    = {1'b0, it.start};
        span_row    = 0;
        column_starts++;
      end
      CMD_PIXEL: begin
        // once the bottom row is out the column stays silent until a start
        if (span_row < IMG_ROWS) begin
          if (span_row <= span.top) begin
            px.color = {8'h00, floor_rgb};
          end else if (span_row <= span.bottom) begin
            px.color = wall_hue();
            span_pos = span_pos + {1'b0, span.step};
            wall_rows++;
          end else begin
            px.color = {8'h00, ceil_rgb};
          end
          px.row    = span_row[8:0];
          px.column = span.scol;
          px.last   = (span_row == IMG_ROWS - 1);
          pixels_due.push_back(px);
          span_row++;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drive one item and hold it until taken; idle first at the current gap rate.
  task automatic send_item(input span_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {4'b0, it.scol, it.frame, it.ovl_on, it.bottom, it.top, it.step,
                 it.start, it.tcol, it.side, it.value, it.addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_column(it);
  endtask

  function automatic span_item_t random_item();
    span_item_t it;
    it.cmd    = 2'($urandom);
    it.addr   = 14'($urandom);
    it.value  = $urandom;
    it.side   = 3'($urandom);
    it.tcol   = 6'($urandom);
    it.start  = 31'($urandom);
    it.step   = 31'($urandom);
    it.top    = 9'($urandom);
    it.bottom = 9'($urandom);
    it.ovl_on = 1'($urandom);
    it.frame  = 2'($urandom);
    it.scol   = 10'($urandom);
    return it;
  endfunction

  function automatic span_item_t load_item(input logic [1:0] cmd, input logic [2:0] side,
                                           input logic [1:0] frame, input logic [13:0] addr,
                                           input logic [31:0] value);
    span_item_t it;
    it       = random_item();
    it.cmd   = cmd;
    it.side  = side;
    it.frame = frame;
    it.addr  = addr;
    it.value = value;
    return it;
  endfunction

  function automatic span_item_t start_item(input logic [2:0] side, input logic [5:0] tcol,
                                            input logic [30:0] start, input logic [30:0] step,
                                            input logic [8:0] top, input logic [8:0] bottom,
                                            input logic ovl_on, input logic [1:0] frame,
                                            input logic [9:0] scol);
    span_item_t it;
    it        = random_item();
    it.cmd    = CMD_START;
    it.side   = side;
    it.tcol   = tcol;
    it.start  = start;
    it.step   = step;
    it.top    = top;
    it.bottom = bottom;
    it.ovl_on = ovl_on;
    it.frame  = frame;
    it.scol   = scol;
    return it;
  endfunction

  // Overlay words: transparent zero, negative, or positive
  function automatic logic [31:0] ovl_word();
    case ($urandom_range(3))
      0:       return 32'h0;
      1:       return $urandom | 32'h8000_0000;
      default: return ($urandom & 32'h7FFF_FFFF) | 32'h1;
    endcase
  endfunction

  // A few texture columns are reused so that loaded texels get read again
  function automatic logic [5:0] pick_tcol();
    case ($urandom_range(4))
      0:       return 6'd0;
      1:       return 6'd63;
      2:       return 6'd21;
      3:       return 6'd42;
      default: return 6'($urandom);
    endcase
  endfunction

  // Send a pixel command. Texels the next wall row reads are loaded first if
  // nothing was ever written there, so no read of an unwritten entry happens.
  task automatic send_pixel();
    span_item_t it;
    int         w;
    int         o;
    if (next_is_wall()) begin
      if (span.side < WALL_TEXTURES) begin
        w = wall_slot();
        if (!wall_written[w])
          send_item(load_item(CMD_LOAD_WALL, span.side, 2'($urandom), 14'(w % WALL_AREA),
                              $urandom));
      end
      if (span.ovl_on && span.frame < OVL_FRAMES) begin
        o = ovl_slot();
        if (!ovl_written[o])
          send_item(load_item(CMD_LOAD_OVERLAY, 3'($urandom), span.frame, 14'(o % OVL_AREA),
                              ovl_word()));
      end
    end
    it = random_item();
    it.cmd = CMD_PIXEL;
    send_item(it);
  endtask

  // Drop valid, let every expected pixel arrive, then let the pipeline empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write both color registers on consecutive edges; only called while idle.
  task automatic set_colors(input logic [23:0] floor_c, input logic [23:0] ceil_c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FLOOR_COLOR;
    cfg_data  <= floor_c;
    @(posedge clk);
    cfg_index <= CFG_CEILING_COLOR;
    cfg_data  <= ceil_c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    floor_rgb = floor_c;
    ceil_rgb  = ceil_c;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pixels with no start yet use the all-zero setup: row 0 floor, then ceiling.
  task automatic test_pixel_before_start();
    repeat (2) send_pixel();
  endtask

  // Extremes of the fields, dropped loads, overlay priority, shading, missing
  // texture, and an empty wall span.
  task automatic test_directed_column();
    send_item(load_item(CMD_LOAD_WALL, 3'd0, 2'd0, 14'd0, 32'hFFFF_FFFF));
    send_item(load_item(CMD_LOAD_WALL, 3'd4, 2'd0, 14'd4095, 32'h80FF_01FE));
    // side past the last texture, and address past the texture area: dropped
    send_item(load_item(CMD_LOAD_WALL, 3'd7, 2'd0, 14'd0, 32'h1234_5678));
    send_item(load_item(CMD_LOAD_WALL, 3'd2, 2'd0, 14'd16383, 32'h0BAD_0BAD));
    send_item(load_item(CMD_LOAD_OVERLAY, 3'd0, 2'd3, 14'd16383, 32'h7FFF_FFFF));
    // overlay rows 0..2 at column 0: positive, negative, transparent
    send_item(load_item(CMD_LOAD_OVERLAY, 3'd0, 2'd0, 14'd0, 32'h0000_0001));
    send_item(load_item(CMD_LOAD_OVERLAY, 3'd0, 2'd0, 14'd128, 32'h8000_0000));
    send_item(load_item(CMD_LOAD_OVERLAY, 3'd0, 2'd0, 14'd256, 32'h0000_0000));
    send_item(start_item(3'd0, 6'd0, 31'd0, 31'h1_0000, 9'd0, 9'd3, 1'b1, 2'd0, 10'd0));
    repeat (5) send_pixel();
    // shaded face, largest position and step, widest screen column
    send_item(start_item(3'd4, 6'd63, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 9'd0, 9'd2, 1'b0, 2'd3,
                         10'd1023));
    repeat (3) send_pixel();
    // missing wall texture under the last overlay row
    send_item(start_item(3'd7, 6'd21, 31'h007F_0000, 31'd0, 9'd0, 9'd511, 1'b1, 2'd3,
                         10'd512));
    repeat (2) send_pixel();
    // bottom above top: floor then straight to ceiling
    send_item(start_item(3'd2, 6'd42, 31'd0, 31'h1_0000, 9'd3, 9'd2, 1'b1, 2'd1, 10'd341));
    repeat (5) send_pixel();
  endtask

  // A whole column down to the last row, then a few pixels that yield nothing.
  task automatic test_full_column();
    send_item(start_item(3'd1, pick_tcol(), 31'($urandom_range(0, 32'h3F_FFFF)), 31'h4000,
                         9'd200, 9'd511, 1'b1, 2'($urandom), 10'($urandom)));
    repeat (IMG_ROWS + 3) send_pixel();
  endtask

  // Short columns with random setups; some stray loads in between, and now
  // and then a column that keeps running without a new start.
  task automatic test_random_columns(input int quota);
    span_item_t it;
    int         stop_at;
    int         n_pix;
    logic [8:0] top;
    logic [8:0] bottom;
    logic [30:0] start;
    logic [30:0] step;
    stop_at = items_taken + quota;
    while (items_taken < stop_at) begin
      if ($urandom_range(19) != 0) begin
        case ($urandom_range(9))
          0: begin
            top    = 9'($urandom);
            bottom = 9'($urandom);
          end
          1: begin
            top    = 9'($urandom_range(1, 20));
            bottom = 9'($urandom_range(0, top));
          end
          default: begin
            top    = 9'($urandom_range(0, 10));
            bottom = top + 9'($urandom_range(1, 40));
          end
        endcase
        case ($urandom_range(3))
          0:       start = 31'd0;
          1:       start = 31'h7FFF_FFFF;
          2:       start = 31'($urandom);
          default: start = 31'($urandom_range(0, 32'h3F_FFFF));
        endcase
        case ($urandom_range(5))
          0:       step = 31'd0;
          1:       step = 31'($urandom);
          2:       step = 31'h7FFF_FFFF;
          default: step = 31'($urandom_range(0, 32'h3_0000));
        endcase
        send_item(start_item(($urandom_range(9) < 8) ? 3'($urandom_range(0, 4))
                                                      : 3'($urandom_range(5, 7)),
                             pick_tcol(), start, step, top, bottom, 1'($urandom),
                             2'($urandom), 10'($urandom)));
      end
      n_pix = $urandom_range(1, 40);
      repeat (n_pix) begin
        if ($urandom_range(9) == 0) begin
          it = random_item();
          it.cmd = $urandom_range(1) ? CMD_LOAD_WALL : CMD_LOAD_OVERLAY;
          if ($urandom_range(1)) it.addr = 14'($urandom_range(0, WALL_AREA - 1));
          if (it.cmd == CMD_LOAD_OVERLAY) it.value = ovl_word();
          send_item(it);
        end
        send_pixel();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready, compare each taken pixel with the oldest one due
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      pixels_seen++;
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: pixel with none due, expected nothing, actual %0h last %0b",
                   $time, m_tdata, m_tlast);
      end else begin
        want = pixels_due.pop_front();
        check_field("pixel_row", 32'(want.row), 32'(m_tdata[8:0]));
        check_field("pixel_column", 32'(want.column), 32'(m_tdata[18:9]));
        check_field("pixel_color", want.color, m_tdata[50:19]);
        check_field("last_pixel", 32'(want.last), 32'(m_tlast));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run if nothing moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence: busy sender with a slow receiver, then the reverse, then
  // both at full rate.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_pixel_before_start();
    settle();
    set_colors(24'hFF_FFFF, 24'h00_0000);
    test_directed_column();
    test_random_columns(250);

    settle();
    send_gap_pct   = 76;
    recv_stall_pct = 16;
    set_colors(24'h00_0000, 24'hFF_FFFF);
    test_random_columns(250);

    settle();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    set_colors(24'($urandom), 24'($urandom));
    test_full_column();
    test_random_columns(200);

    settle();
    $display("Ran %0d items: %0d texel loads, %0d column starts, %0d wall rows drawn",
             items_taken, texel_loads, column_starts, wall_rows);
    $display("Checked %0d pixels under three valid/ready idle patterns and four color settings",
             pixels_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tcsr_pkg.sv
hw/rtl/tcsr_ram.sv
hw/rtl/textured_column_span_renderer_core.sv
tb/tb_top.sv
